@@ rtl/core/arc_pkg.sv @@
// Package for the ARP resolver cache: sizes, opcodes, result kinds, config
// indices, and the entry and write command structs shared with the entry store.
// No dependencies.
package arc_pkg;

    localparam int CACHE_ENTRIES = 16;
    localparam int IDX_W = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;

    localparam logic [15:0] ARPOP_REQ = 16'd1;
    localparam logic [15:0] ARPOP_RSP = 16'd2;

    localparam logic [2:0] OP_PACKET  = 3'd0;
    localparam logic [2:0] OP_LOOKUP  = 3'd1;
    localparam logic [2:0] OP_RESOLVE = 3'd2;
    localparam logic [2:0] OP_TICK    = 3'd3;
    localparam logic [2:0] OP_REVERSE = 3'd4;
    localparam logic [2:0] OP_FLUSH   = 3'd5;

    localparam logic [2:0] K_SEND_REQUEST = 3'd0;
    localparam logic [2:0] K_SEND_REPLY   = 3'd1;
    localparam logic [2:0] K_MAC_ANSWER   = 3'd2;
    localparam logic [2:0] K_IP_ANSWER    = 3'd3;
    localparam logic [2:0] K_FAILED       = 3'd4;
    localparam logic [2:0] K_DONE         = 3'd5;
    localparam logic [2:0] K_BAD_PACKET   = 3'd6;
    localparam logic [2:0] K_TABLE_FULL   = 3'd7;

    localparam logic [2:0] CFG_MY_IP         = 3'd0;
    localparam logic [2:0] CFG_MY_MAC        = 3'd1;
    localparam logic [2:0] CFG_RETRY_TIMEOUT = 3'd2;
    localparam logic [2:0] CFG_RETRY_COUNT   = 3'd3;
    localparam logic [2:0] CFG_CACHE_TIMEOUT = 3'd4;

    // One entry as read from or written to the entry store.
    typedef struct packed {
        logic [31:0] ip;
        logic [47:0] mac;
        logic [31:0] updated;
        logic [7:0]  retries;
        logic [31:0] deadline;
    } entry_t;

    // Write command from the sequencer to the entry store.
    typedef struct packed {
        logic             wr;
        logic [IDX_W-1:0] idx;
        logic             valid;
        logic             pending;
        entry_t           data;
    } entry_wr_t;

    // Saturating add of two 32-bit values.
    function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

endpackage

@@ rtl/core/arc_ram.sv @@
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
module arc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and read the array
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

@@ rtl/core/arc_store.sv @@
// Entry store: payload RAM plus valid/pending flag registers.
// Depends on arc_pkg and arc_ram.
module arc_store
    import arc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  entry_wr_t        wcmd,
    input  logic             clear_all,
    input  logic [IDX_W-1:0] rd_idx,
    output entry_t           rd_data,
    output logic             rd_valid,
    output logic             rd_pending
);

    logic [CACHE_ENTRIES-1:0] valid_reg;
    logic [CACHE_ENTRIES-1:0] pending_reg;
    logic                     rv_reg;
    logic                     rp_reg;

    arc_ram #(
        .WIDTH($bits(entry_t)),
        .DEPTH(CACHE_ENTRIES)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wcmd.wr),
        .wr_addr (wcmd.idx),
        .wr_data (wcmd.data),
        .rd_addr (rd_idx),
        .rd_data (rd_data)
    );

    // Hold flags; flush clears all at once
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= '0;
            pending_reg <= '0;
            rv_reg      <= 1'b0;
            rp_reg      <= 1'b0;
        end
        else
        begin
            rv_reg <= valid_reg[rd_idx];
            rp_reg <= pending_reg[rd_idx];
            if (clear_all)
            begin
                valid_reg   <= '0;
                pending_reg <= '0;
            end
            else if (wcmd.wr)
            begin
                valid_reg[wcmd.idx]   <= wcmd.valid;
                pending_reg[wcmd.idx] <= wcmd.pending;
            end
        end
    end

    assign rd_valid   = rv_reg;
    assign rd_pending = rp_reg;

endmodule

@@ rtl/core/arp_resolver_cache.sv @@
// Top level of the ARP resolver cache: config registers, sequencer, output.
// Depends on arc_pkg and arc_store.
//
//  channel | signals                                      | dir
//  in      | in_valid/in_ready, opcode..arp_op             | in
//  out     | out_valid/out_ready, kind..last               | out
//  cfg     | cfg_we, cfg_index, cfg_data                   | in
//
// Packet, lookup, resolve and reverse lookup scan the store entry by entry
// (registered read) up to the final result; a new entry costs a second scan
// for a free or stalest slot, and a write back goes through the commit state.
// A tick walks the store entry by entry; a flush or unused opcode goes straight
// to the decide state. Input is ready again once the final result is loaded.
// Reset clears valid/pending flags and tick clock; entry payload is unset.
// A result waits in the output register; emitting states stall until it is taken.
module arp_resolver_cache
    import arc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  opcode,
    input  logic [31:0] ip_addr,
    input  logic [47:0] mac_addr,
    input  logic [31:0] target_ip,
    input  logic [15:0] arp_op,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  kind,
    output logic        found,
    output logic [31:0] out_ip,
    output logic [47:0] out_mac,
    output logic [31:0] reply_src_ip,
    output logic        last,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [47:0] cfg_data
);

    typedef enum logic [3:0] {
        S_IDLE, S_FIND_A, S_FIND_W, S_FIND_C, S_DECIDE, S_ALLOC_A, S_ALLOC_W,
        S_ALLOC_C, S_COMMIT, S_TICK_A, S_TICK_W, S_TICK_C, S_EMIT, S_FINAL
    } state_t;

    state_t state_reg;

    logic [31:0] my_ip_reg, retry_timeout_reg, cache_timeout_reg, tick_now_reg;
    logic [47:0] my_mac_reg;
    logic [7:0]  retry_count_reg;

    logic [2:0]  op_reg;
    logic [31:0] ip_reg, tgt_reg;
    logic [47:0] mac_reg;
    logic [15:0] aop_reg;

    logic [IDX_W-1:0] idx_reg;
    logic             hit_reg;
    logic [IDX_W-1:0] hit_idx_reg;
    entry_t           hit_ent_reg;
    logic             hit_pend_reg;
    logic             free_reg;
    logic [IDX_W-1:0] best_idx_reg;
    logic [31:0]      best_key_reg;
    logic             best_ok_reg;
    logic             rev_ok_reg;
    logic [31:0]      rev_ip_reg;

    // Pending result, plus the final result still to follow it
    logic        ob_valid_reg;
    logic [2:0]  ob_kind_reg;
    logic        ob_found_reg, ob_last_reg;
    logic [31:0] ob_ip_reg, ob_src_reg;
    logic [47:0] ob_mac_reg;
    logic [2:0]  fin_kind_reg;
    logic [31:0] fin_ip_reg, fin_src_reg;
    logic [47:0] fin_mac_reg;
    logic        fin_found_reg;
    state_t      ret_reg;

    entry_wr_t   wcmd;
    logic        clear_all;
    logic [IDX_W-1:0] rd_idx;
    entry_t      rd_data;
    logic        rd_valid, rd_pending;

    arc_store u_store (
        .clk        (clk),
        .rst_n      (rst_n),
        .wcmd       (wcmd),
        .clear_all  (clear_all),
        .rd_idx     (rd_idx),
        .rd_data    (rd_data),
        .rd_valid   (rd_valid),
        .rd_pending (rd_pending)
    );

    assign rd_idx = idx_reg;

    logic fresh;
    logic [32:0] fresh_sum;
    assign fresh_sum = {1'b0, rd_data.updated} + {1'b0, cache_timeout_reg};
    assign fresh = fresh_sum >= {1'b0, tick_now_reg};

    logic [31:0] new_deadline;
    assign new_deadline = sat_add32(tick_now_reg, retry_timeout_reg);

    logic last_idx;
    assign last_idx = (idx_reg == IDX_W'(CACHE_ENTRIES - 1));

    logic out_free;
    assign out_free = !ob_valid_reg || out_ready;

    // Tick compare and retry counters for the entry in hand
    logic [7:0] retries_inc;
    assign retries_inc = (rd_data.retries == 8'hFF) ? 8'hFF : rd_data.retries + 8'd1;
    logic tick_due;
    assign tick_due = rd_valid && rd_pending && (rd_data.deadline <= tick_now_reg);

    // Output register loads a new result this cycle
    logic ob_load;
    assign ob_load = out_free && ((state_reg == S_EMIT) || (state_reg == S_FINAL) ||
                                  (state_reg == S_TICK_C && tick_due));

    logic pkt_zero;
    assign pkt_zero = (ip_reg == 32'd0) || (mac_reg == 48'd0);

    logic [2:0] pkt_kind;
    always_comb
    begin
        if (aop_reg == ARPOP_REQ)
        begin
            pkt_kind = K_SEND_REPLY;
        end
        else if (aop_reg == ARPOP_RSP)
        begin
            pkt_kind = K_DONE;
        end
        else
        begin
            pkt_kind = K_BAD_PACKET;
        end
    end

    // Slot choice on the last entry of the allocation scan
    logic             all_pending;
    logic [IDX_W-1:0] alloc_idx;
    always_comb
    begin
        all_pending = !free_reg && rd_valid && rd_pending && !best_ok_reg;
        if (free_reg)
        begin
            alloc_idx = hit_idx_reg;
        end
        else if (!rd_valid)
        begin
            alloc_idx = rd_idx;
        end
        else if (!rd_pending && (!best_ok_reg || rd_data.updated < best_key_reg))
        begin
            alloc_idx = rd_idx;
        end
        else
        begin
            alloc_idx = best_idx_reg;
        end
    end

    // Write command for the entry store
    always_comb
    begin
        wcmd       = '0;
        clear_all  = 1'b0;
        wcmd.idx   = hit_idx_reg;
        wcmd.data  = hit_ent_reg;
        if (state_reg == S_COMMIT)
        begin
            wcmd.wr    = 1'b1;
            wcmd.valid = 1'b1;
            if (op_reg == OP_RESOLVE)
            begin
                wcmd.pending       = 1'b1;
                wcmd.data.ip       = ip_reg;
                wcmd.data.mac      = '0;
                wcmd.data.updated  = '0;
                wcmd.data.retries  = '0;
                wcmd.data.deadline = new_deadline;
            end
            else
            begin
                wcmd.pending      = 1'b0;
                wcmd.data.ip      = ip_reg;
                wcmd.data.mac     = mac_reg;
                wcmd.data.updated = tick_now_reg;
                wcmd.data.retries = '0;
                if (!hit_reg)
                begin
                    wcmd.data.deadline = '0;
                end
            end
        end
        else if (state_reg == S_TICK_C && tick_due && out_free)
        begin
            wcmd.wr   = 1'b1;
            wcmd.idx  = rd_idx;
            wcmd.data = rd_data;
            wcmd.data.retries = retries_inc;
            if (retries_inc < retry_count_reg)
            begin
                wcmd.valid   = 1'b1;
                wcmd.pending = 1'b1;
                wcmd.data.deadline = new_deadline;
            end
        end
        else if (state_reg == S_DECIDE && op_reg == OP_FLUSH)
        begin
            clear_all = 1'b1;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

    // Sequencer, config registers and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            my_ip_reg         <= '0;
            my_mac_reg        <= '0;
            retry_timeout_reg <= 32'd1;
            retry_count_reg   <= 8'd3;
            cache_timeout_reg <= 32'd120;
            tick_now_reg      <= '0;
            ob_valid_reg      <= 1'b0;
            ret_reg           <= S_IDLE;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_MY_IP:         my_ip_reg         <= cfg_data[31:0];
                    CFG_MY_MAC:        my_mac_reg        <= cfg_data;
                    CFG_RETRY_TIMEOUT: retry_timeout_reg <= cfg_data[31:0];
                    CFG_RETRY_COUNT:   retry_count_reg   <= cfg_data[7:0];
                    CFG_CACHE_TIMEOUT: cache_timeout_reg <= cfg_data[31:0];
                    default: ;
                endcase
            end

            // Drop the taken result unless a new one replaces it
            if (ob_valid_reg && out_ready && !ob_load)
            begin
                ob_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        op_reg       <= opcode;
                        ip_reg       <= ip_addr;
                        mac_reg      <= mac_addr;
                        tgt_reg      <= target_ip;
                        aop_reg      <= arp_op;
                        idx_reg      <= '0;
                        hit_reg      <= 1'b0;
                        free_reg     <= 1'b0;
                        best_ok_reg  <= 1'b0;
                        rev_ok_reg   <= 1'b0;
                        fin_found_reg <= 1'b0;
                        fin_ip_reg   <= '0;
                        fin_mac_reg  <= '0;
                        fin_src_reg  <= '0;
                        fin_kind_reg <= K_DONE;
                        if (opcode == OP_TICK)
                        begin
                            if (tick_now_reg != 32'hFFFF_FFFF)
                            begin
                                tick_now_reg <= tick_now_reg + 32'd1;
                            end
                            state_reg <= S_TICK_A;
                        end
                        else if (opcode == OP_FLUSH || opcode > OP_FLUSH)
                        begin
                            state_reg <= S_DECIDE;
                        end
                        else
                        begin
                            state_reg <= S_FIND_A;
                        end
                    end
                end
                S_FIND_A: state_reg <= S_FIND_W;
                S_FIND_W: state_reg <= S_FIND_C;
                S_FIND_C:
                begin
                    // First IP match; reverse lookup keeps the lowest fresh IP
                    if (!hit_reg && rd_valid && rd_data.ip == ip_reg)
                    begin
                        hit_reg      <= 1'b1;
                        hit_idx_reg  <= rd_idx;
                        hit_ent_reg  <= rd_data;
                        hit_pend_reg <= rd_pending;
                        fin_found_reg <= fresh && !rd_pending;
                    end
                    if (rd_valid && rd_data.mac == mac_reg && fresh &&
                        (!rev_ok_reg || rd_data.ip < rev_ip_reg))
                    begin
                        rev_ok_reg <= 1'b1;
                        rev_ip_reg <= rd_data.ip;
                    end
                    if (last_idx)
                    begin
                        state_reg <= S_DECIDE;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + IDX_W'(1);
                        state_reg <= S_FIND_W;
                    end
                end
                S_DECIDE:
                begin
                    case (op_reg)
                        OP_PACKET:
                        begin
                            if (pkt_zero)
                            begin
                                fin_kind_reg <= K_BAD_PACKET;
                                state_reg    <= S_FINAL;
                            end
                            else if (tgt_reg != my_ip_reg)
                            begin
                                state_reg <= hit_reg ? S_COMMIT : S_FINAL;
                                ret_reg   <= S_FINAL;
                            end
                            else
                            begin
                                fin_kind_reg <= pkt_kind;
                                if (pkt_kind == K_SEND_REPLY)
                                begin
                                    fin_ip_reg  <= ip_reg;
                                    fin_mac_reg <= mac_reg;
                                    fin_src_reg <= tgt_reg;
                                end
                                ret_reg   <= S_FINAL;
                                if (hit_reg)
                                begin
                                    state_reg <= S_COMMIT;
                                end
                                else
                                begin
                                    idx_reg   <= '0;
                                    state_reg <= S_ALLOC_A;
                                end
                            end
                        end
                        OP_LOOKUP:
                        begin
                            fin_kind_reg <= K_MAC_ANSWER;
                            fin_ip_reg   <= ip_reg;
                            fin_mac_reg  <= fin_found_reg ? hit_ent_reg.mac : 48'd0;
                            state_reg    <= S_FINAL;
                        end
                        OP_RESOLVE:
                        begin
                            if (hit_reg && hit_pend_reg)
                            begin
                                fin_kind_reg <= K_DONE;
                                state_reg    <= S_FINAL;
                            end
                            else
                            begin
                                fin_kind_reg <= K_SEND_REQUEST;
                                fin_ip_reg   <= ip_reg;
                                ret_reg      <= S_FINAL;
                                if (hit_reg)
                                begin
                                    state_reg <= S_COMMIT;
                                end
                                else
                                begin
                                    idx_reg   <= '0;
                                    state_reg <= S_ALLOC_A;
                                end
                            end
                        end
                        OP_REVERSE:
                        begin
                            fin_kind_reg  <= K_IP_ANSWER;
                            fin_found_reg <= rev_ok_reg && mac_reg != 48'd0;
                            fin_ip_reg    <= (rev_ok_reg && mac_reg != 48'd0) ?
                                             rev_ip_reg : 32'd0;
                            state_reg     <= S_FINAL;
                        end
                        default:
                        begin
                            fin_kind_reg <= K_DONE;
                            state_reg    <= S_FINAL;
                        end
                    endcase
                end
                S_ALLOC_A: state_reg <= S_ALLOC_W;
                S_ALLOC_W: state_reg <= S_ALLOC_C;
                S_ALLOC_C:
                begin
                    // Lowest free slot, else stalest settled entry
                    if (last_idx)
                    begin
                        if (all_pending)
                        begin
                            // Every entry pending: report and skip the store
                            if (op_reg == OP_RESOLVE)
                            begin
                                fin_kind_reg <= K_TABLE_FULL;
                                state_reg    <= S_FINAL;
                            end
                            else
                            begin
                                state_reg <= S_EMIT;
                            end
                        end
                        else
                        begin
                            hit_idx_reg <= alloc_idx;
                            state_reg   <= S_COMMIT;
                        end
                    end
                    else
                    begin
                        if (!free_reg && !rd_valid)
                        begin
                            free_reg    <= 1'b1;
                            hit_idx_reg <= rd_idx;
                        end
                        if (rd_valid && !rd_pending &&
                            (!best_ok_reg || rd_data.updated < best_key_reg))
                        begin
                            best_ok_reg  <= 1'b1;
                            best_idx_reg <= rd_idx;
                            best_key_reg <= rd_data.updated;
                        end
                        idx_reg   <= idx_reg + IDX_W'(1);
                        state_reg <= S_ALLOC_W;
                    end
                end
                S_COMMIT:
                begin
                    state_reg <= ret_reg;
                end
                S_EMIT:
                begin
                    if (out_free)
                    begin
                        ob_valid_reg <= 1'b1;
                        ob_kind_reg  <= K_TABLE_FULL;
                        ob_found_reg <= 1'b0;
                        ob_ip_reg    <= ip_reg;
                        ob_mac_reg   <= '0;
                        ob_src_reg   <= '0;
                        ob_last_reg  <= 1'b0;
                        state_reg    <= S_FINAL;
                    end
                end
                S_TICK_A: state_reg <= S_TICK_W;
                S_TICK_W: state_reg <= S_TICK_C;
                S_TICK_C:
                begin
                    if (out_free)
                    begin
                        if (tick_due)
                        begin
                            ob_valid_reg <= 1'b1;
                            ob_kind_reg  <= (retries_inc < retry_count_reg) ?
                                            K_SEND_REQUEST : K_FAILED;
                            ob_found_reg <= 1'b0;
                            ob_ip_reg    <= rd_data.ip;
                            ob_mac_reg   <= '0;
                            ob_src_reg   <= '0;
                            ob_last_reg  <= 1'b0;
                        end
                        if (last_idx)
                        begin
                            state_reg <= S_FINAL;
                        end
                        else
                        begin
                            idx_reg   <= idx_reg + IDX_W'(1);
                            state_reg <= S_TICK_A;
                        end
                    end
                end
                S_FINAL:
                begin
                    if (out_free)
                    begin
                        ob_valid_reg <= 1'b1;
                        ob_kind_reg  <= fin_kind_reg;
                        ob_found_reg <= fin_found_reg && (fin_kind_reg == K_MAC_ANSWER ||
                                        fin_kind_reg == K_IP_ANSWER);
                        ob_ip_reg    <= fin_ip_reg;
                        ob_mac_reg   <= fin_mac_reg;
                        ob_src_reg   <= fin_src_reg;
                        ob_last_reg  <= 1'b1;
                        state_reg    <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign out_valid    = ob_valid_reg;
    assign kind         = ob_kind_reg;
    assign found        = ob_found_reg;
    assign out_ip       = ob_ip_reg;
    assign out_mac      = ob_mac_reg;
    assign reply_src_ip = ob_src_reg;
    assign last         = ob_last_reg;

    // No new transaction accepted while a scan is running
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !in_ready)
        else $error("input accepted during scan");
    // A held result never changes until taken
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(kind) && $stable(out_ip)))
        else $error("result changed while stalled");
    // Store is written only in commit or tick scan
    a_wr: assert property (@(posedge clk) disable iff (!rst_n)
        wcmd.wr |-> (state_reg == S_COMMIT || state_reg == S_TICK_C))
        else $error("unexpected entry write");

endmodule

@@ tb/arc_checker.sv @@
// Result checker for the ARP resolver cache: mirrors the cache, predicts the
// results of each accepted request and compares them with the output channel.
// Depends on arc_pkg.
module arc_checker
    import arc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [2:0]  opcode,
    input  logic [31:0] ip_addr,
    input  logic [47:0] mac_addr,
    input  logic [31:0] target_ip,
    input  logic [15:0] arp_op,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [2:0]  kind,
    input  logic        found,
    input  logic [31:0] out_ip,
    input  logic [47:0] out_mac,
    input  logic [31:0] reply_src_ip,
    input  logic        last,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [47:0] cfg_data,
    output int          fail_count,
    output int          pending_results,
    output int          results_seen
);

    typedef struct packed {
        logic [2:0]  kind;
        logic        found;
        logic [31:0] ip;
        logic [47:0] mac;
        logic [31:0] src;
        logic        last;
    } arp_result_t;

    arp_result_t expected_q[$];

    logic [31:0] my_ip_r, retry_to_r, cache_to_r;
    logic [47:0] my_mac_r;
    logic [7:0]  retry_cnt_r;

    logic        c_valid   [CACHE_ENTRIES];
    logic        c_pending [CACHE_ENTRIES];
    logic [31:0] c_ip      [CACHE_ENTRIES];
    logic [47:0] c_mac     [CACHE_ENTRIES];
    logic [31:0] c_updated [CACHE_ENTRIES];
    logic [7:0]  c_retries [CACHE_ENTRIES];
    logic [31:0] c_deadline[CACHE_ENTRIES];
    logic [31:0] clock_now;

    function automatic void push(logic [2:0] k, logic f, logic [31:0] ip,
                                 logic [47:0] mac, logic [31:0] src);
        arp_result_t r;
        r = '{k, f, ip, mac, src, 1'b0};
        expected_q.push_back(r);
    endfunction

    function automatic int find_entry(logic [31:0] ip);
        for (int i = 0; i < CACHE_ENTRIES; i++)
            if (c_valid[i] && c_ip[i] == ip)
                return i;
        return -1;
    endfunction

    function automatic logic entry_fresh(int i);
        return ({1'b0, c_updated[i]} + {1'b0, cache_to_r}) >= {1'b0, clock_now};
    endfunction

    function automatic logic [31:0] next_deadline();
        logic [32:0] s;
        s = {1'b0, clock_now} + {1'b0, retry_to_r};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    function automatic int pick_slot();
        int b;
        b = -1;
        for (int i = 0; i < CACHE_ENTRIES; i++)
            if (!c_valid[i])
                return i;
        for (int i = 0; i < CACHE_ENTRIES; i++)
            if (!c_pending[i] && (b < 0 || c_updated[i] < c_updated[b]))
                b = i;
        return b;
    endfunction

    function automatic void settle_entry(int i, logic [47:0] mac);
        c_pending[i] = 1'b0;
        c_retries[i] = '0;
        c_mac[i] = mac;
        c_updated[i] = clock_now;
    endfunction

    // Predict all results of one request transaction and queue them.
    function automatic void predict_request(logic [2:0] op, logic [31:0] ip,
                                            logic [47:0] mac, logic [31:0] tgt,
                                            logic [15:0] aop);
        int i, b;
        case (op)
            OP_PACKET:
                if (ip == 0 || mac == 0)
                    push(K_BAD_PACKET, 0, 0, 0, 0);
                else begin
                    i = find_entry(ip);
                    if (i >= 0)
                        settle_entry(i, mac);
                    if (tgt != my_ip_r)
                        push(K_DONE, 0, 0, 0, 0);
                    else begin
                        if (i < 0) begin
                            i = pick_slot();
                            if (i < 0)
                                push(K_TABLE_FULL, 0, ip, 0, 0);
                            else begin
                                c_valid[i] = 1'b1;
                                c_ip[i] = ip;
                                c_deadline[i] = '0;
                                settle_entry(i, mac);
                            end
                        end
                        if (aop == ARPOP_REQ)
                            push(K_SEND_REPLY, 0, ip, mac, tgt);
                        else if (aop == ARPOP_RSP)
                            push(K_DONE, 0, 0, 0, 0);
                        else
                            push(K_BAD_PACKET, 0, 0, 0, 0);
                    end
                end
            OP_LOOKUP: begin
                i = find_entry(ip);
                if (i >= 0 && !c_pending[i] && entry_fresh(i))
                    push(K_MAC_ANSWER, 1, ip, c_mac[i], 0);
                else
                    push(K_MAC_ANSWER, 0, ip, 0, 0);
            end
            OP_RESOLVE: begin
                i = find_entry(ip);
                if (i >= 0 && c_pending[i])
                    push(K_DONE, 0, 0, 0, 0);
                else begin
                    if (i < 0)
                        i = pick_slot();
                    if (i < 0)
                        push(K_TABLE_FULL, 0, ip, 0, 0);
                    else begin
                        c_valid[i] = 1'b1;
                        c_ip[i] = ip;
                        c_pending[i] = 1'b1;
                        c_retries[i] = '0;
                        c_mac[i] = '0;
                        c_updated[i] = '0;
                        c_deadline[i] = next_deadline();
                        push(K_SEND_REQUEST, 0, ip, 0, 0);
                    end
                end
            end
            OP_TICK: begin
                if (clock_now != 32'hFFFF_FFFF)
                    clock_now++;
                for (int k = 0; k < CACHE_ENTRIES; k++) begin
                    if (c_valid[k] && c_pending[k] && c_deadline[k] <= clock_now) begin
                        if (c_retries[k] != 8'hFF)
                            c_retries[k]++;
                        if (c_retries[k] < retry_cnt_r) begin
                            c_deadline[k] = next_deadline();
                            push(K_SEND_REQUEST, 0, c_ip[k], 0, 0);
                        end else begin
                            c_valid[k] = 1'b0;
                            c_pending[k] = 1'b0;
                            push(K_FAILED, 0, c_ip[k], 0, 0);
                        end
                    end
                end
                push(K_DONE, 0, 0, 0, 0);
            end
            OP_REVERSE: begin
                b = -1;
                if (mac != 0)
                    for (int k = 0; k < CACHE_ENTRIES; k++)
                        if (c_valid[k] && c_mac[k] == mac && entry_fresh(k) &&
                            (b < 0 || c_ip[k] < c_ip[b]))
                            b = k;
                if (b >= 0)
                    push(K_IP_ANSWER, 1, c_ip[b], 0, 0);
                else
                    push(K_IP_ANSWER, 0, 0, 0, 0);
            end
            OP_FLUSH: begin
                for (int k = 0; k < CACHE_ENTRIES; k++) begin
                    c_valid[k] = 1'b0;
                    c_pending[k] = 1'b0;
                end
                push(K_DONE, 0, 0, 0, 0);
            end
            default:
                push(K_DONE, 0, 0, 0, 0);
        endcase
        expected_q[expected_q.size() - 1].last = 1'b1;
    endfunction

    // Track config, predict on input transactions, compare on output ones.
    always @(posedge clk or negedge rst_n) begin
        arp_result_t e;
        if (!rst_n) begin
            my_ip_r <= '0;
            my_mac_r <= '0;
            retry_to_r <= 32'd1;
            retry_cnt_r <= 8'd3;
            cache_to_r <= 32'd120;
            clock_now = '0;
            for (int k = 0; k < CACHE_ENTRIES; k++) begin
                c_valid[k] = 1'b0;
                c_pending[k] = 1'b0;
            end
            expected_q.delete();
            fail_count <= 0;
            results_seen <= 0;
            pending_results <= 0;
        end else begin
            if (cfg_we)
                case (cfg_index)
                    CFG_MY_IP:         my_ip_r <= cfg_data[31:0];
                    CFG_MY_MAC:        my_mac_r <= cfg_data;
                    CFG_RETRY_TIMEOUT: retry_to_r <= cfg_data[31:0];
                    CFG_RETRY_COUNT:   retry_cnt_r <= cfg_data[7:0];
                    CFG_CACHE_TIMEOUT: cache_to_r <= cfg_data[31:0];
                    default: ;
                endcase
            if (out_valid && out_ready) begin
                results_seen <= results_seen + 1;
                if (expected_q.size() == 0) begin
                    $error("unexpected result kind=%0d", kind);
                    fail_count <= fail_count + 1;
                end else begin
                    e = expected_q.pop_front();
                    if (e.kind !== kind || e.found !== found || e.ip !== out_ip ||
                        e.mac !== out_mac || e.src !== reply_src_ip ||
                        e.last !== last)
                        fail_count <= fail_count + 1;
                    if (e.kind !== kind)
                        $error("kind: expected %0d actual %0d", e.kind, kind);
                    if (e.found !== found)
                        $error("found: expected %0d actual %0d", e.found, found);
                    if (e.ip !== out_ip)
                        $error("out_ip: expected %h actual %h", e.ip, out_ip);
                    if (e.mac !== out_mac)
                        $error("out_mac: expected %h actual %h", e.mac, out_mac);
                    if (e.src !== reply_src_ip)
                        $error("reply_src_ip: expected %h actual %h", e.src, reply_src_ip);
                    if (e.last !== last)
                        $error("last: expected %0d actual %0d", e.last, last);
                end
            end
            if (in_valid && in_ready)
                predict_request(opcode, ip_addr, mac_addr, target_ip, arp_op);
            pending_results <= expected_q.size();
        end
    end

endmodule

@@ tb/tb_arp_resolver_cache.sv @@
// Testbench top for the ARP resolver cache: clock, reset, configuration
// phases, directed and random request stimulus, and the verdict.
// Depends on arc_pkg, arp_resolver_cache and arc_checker.
module tb_arp_resolver_cache
    import arc_pkg::*;
;

    logic        clk, rst_n;
    logic        in_valid, in_ready, out_valid, out_ready;
    logic [2:0]  opcode;
    logic [31:0] ip_addr, target_ip;
    logic [47:0] mac_addr;
    logic [15:0] arp_op;
    logic [2:0]  kind;
    logic        found, last;
    logic [31:0] out_ip, reply_src_ip;
    logic [47:0] out_mac;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [47:0] cfg_data;
    int          fail_count, pending_results, results_seen;
    int          cycle_count;
    int          sent;
    logic        sink_steady;
    logic [31:0] node_ip;
    logic [31:0] ip_pool[8];

    localparam int CYCLE_LIMIT = 400000;

    arp_resolver_cache uut (.*);

    arc_checker chk (.*);

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Receiver: stall about 14 percent, except during a steady stretch.
    always @(posedge clk)
    begin
        out_ready <= sink_steady || ($urandom_range(99) >= 14);
    end

    task automatic write_reg(input logic [2:0] idx, input logic [47:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Present one request and hold it until accepted, then release valid.
    task automatic send_request(input logic [2:0] op, input logic [31:0] ip,
                                input logic [47:0] mac, input logic [31:0] tgt,
                                input logic [15:0] aop, input bit gaps);
        if (gaps)
            while ($urandom_range(99) < 14)
                @(posedge clk);
        opcode <= op;
        ip_addr <= ip;
        mac_addr <= mac;
        target_ip <= tgt;
        arp_op <= aop;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        in_valid <= 1'b0;
        sent++;
        @(posedge clk);
    endtask

    task automatic drain();
        while (pending_results != 0 || in_valid)
            @(posedge clk);
        repeat (80) @(posedge clk);
    endtask

    task automatic configure(input logic [31:0] ip, input logic [47:0] mac,
                             input logic [31:0] rto, input logic [7:0] rcnt,
                             input logic [31:0] cto);
        write_reg(CFG_MY_IP, {16'd0, ip});
        write_reg(CFG_MY_MAC, mac);
        write_reg(CFG_RETRY_TIMEOUT, {16'd0, rto});
        write_reg(CFG_RETRY_COUNT, {40'd0, rcnt});
        write_reg(CFG_CACHE_TIMEOUT, {16'd0, cto});
        node_ip = ip;
    endtask

    // Mostly well-formed traffic on a small address pool, some noise.
    task automatic random_phase(input int count, input bit gaps);
        logic [2:0]  op;
        logic [31:0] ip, tgt;
        logic [47:0] mac;
        logic [15:0] aop;
        int          r;
        for (int n = 0; n < count; n++)
        begin
            r = $urandom_range(99);
            op = (r < 30) ? OP_PACKET : (r < 45) ? OP_LOOKUP : (r < 62) ? OP_RESOLVE :
                 (r < 85) ? OP_TICK : (r < 93) ? OP_REVERSE : (r < 96) ? OP_FLUSH :
                 3'($urandom_range(7));
            ip = ($urandom_range(9) == 0) ? $urandom : ip_pool[$urandom_range(7)];
            mac = ($urandom_range(3) == 0) ? {$urandom, $urandom} :
                  48'(ip[7:0] % 4) + 48'h1;
            if ($urandom_range(19) == 0)
                mac = 0;
            tgt = ($urandom_range(4) == 0) ? $urandom : node_ip;
            aop = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(1, 2));
            send_request(op, ip, mac, tgt, aop, gaps);
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cycle_count = 0;
        sent = 0;
        sink_steady = 1'b0;
        in_valid = 1'b0;
        out_ready = 1'b0;
        opcode = '0;
        ip_addr = '0;
        mac_addr = '0;
        target_ip = '0;
        arp_op = '0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        node_ip = '0;
        for (int k = 0; k < 8; k++)
            ip_pool[k] = (k == 7) ? 32'hFFFF_FFFF : 32'h0A00_0001 + k;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        repeat (3) @(posedge clk);

        // Directed: reset defaults, then field extremes and special cases.
        send_request(OP_LOOKUP, 32'h0, 48'h0, 32'h0, 16'h0, 0);
        send_request(OP_PACKET, 32'h0, 48'h1, 32'h0, ARPOP_REQ, 0);
        send_request(OP_PACKET, 32'h5, 48'h0, 32'h0, ARPOP_REQ, 0);
        drain();
        configure(32'hC0A8_0001, 48'h0200_0000_0001, 32'd0, 8'd0, 32'd0);
        send_request(OP_PACKET, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 32'hC0A8_0001,
                     ARPOP_REQ, 0);
        send_request(OP_PACKET, 32'h1, 48'h1, 32'hC0A8_0001, ARPOP_RSP, 0);
        send_request(OP_PACKET, 32'h2, 48'h2, 32'hC0A8_0001, 16'hFFFF, 0);
        send_request(OP_PACKET, 32'h3, 48'h3, 32'h1234_5678, ARPOP_REQ, 0);
        send_request(OP_LOOKUP, 32'hFFFF_FFFF, 48'h0, 32'h0, 16'h0, 0);
        send_request(OP_REVERSE, 32'h0, 48'hFFFF_FFFF_FFFF, 32'h0, 16'h0, 0);
        send_request(OP_REVERSE, 32'h0, 48'h0, 32'h0, 16'h0, 0);
        send_request(OP_RESOLVE, 32'h7, 48'h0, 32'h0, 16'h0, 0);
        send_request(OP_RESOLVE, 32'h7, 48'h0, 32'h0, 16'h0, 0);
        send_request(OP_TICK, 32'h0, 48'h0, 32'h0, 16'h0, 0);
        send_request(OP_TICK, 32'h0, 48'h0, 32'h0, 16'h0, 0);
        send_request(3'd6, 32'h0, 48'h0, 32'h0, 16'h0, 0);
        send_request(3'd7, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF,
                     16'hFFFF, 0);
        send_request(OP_FLUSH, 32'h0, 48'h0, 32'h0, 16'h0, 0);
        drain();

        // Fill the table with pending resolves to force table_full.
        configure(32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, 8'd255,
                  32'hFFFF_FFFF);
        for (int k = 0; k < CACHE_ENTRIES + 1; k++)
            send_request(OP_RESOLVE, 32'h100 + k, 48'h0, 32'h0, 16'h0, 0);
        send_request(OP_PACKET, 32'h900, 48'h9, 32'hFFFF_FFFF, ARPOP_REQ, 0);
        send_request(OP_TICK, 32'h0, 48'h0, 32'h0, 16'h0, 0);
        send_request(OP_FLUSH, 32'h0, 48'h0, 32'h0, 16'h0, 0);
        drain();

        // Random phases across several settings.
        configure(32'h0A00_0003, 48'h0200_0000_00AA, 32'd2, 8'd3, 32'd6);
        random_phase(90, 1);
        drain();
        configure(32'h0A00_0005, 48'h0200_0000_00BB, 32'd1, 8'd1, 32'd120);
        sink_steady = 1'b1;
        random_phase(50, 0);
        drain();
        sink_steady = 1'b0;
        configure(32'hFFFF_FFFF, 48'h0200_0000_00CC, 32'd3, 8'd255, 32'd0);
        random_phase(80, 1);
        drain();

        $display("Run covered %0d requests and %0d results over packet, lookup,",
                 sent, results_seen);
        $display("resolve, tick, reverse lookup and flush with five register settings.");
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
